// File: hdl/qtl_pkg.sv
// Package for the query token lexer: payload types, token and keyword codes,
// and the keyword table with its match helpers. No dependencies.
`default_nettype none

package qtl_pkg;

  // Default counter width for token lengths
  localparam int unsigned LENGTH_BITS_DEF = 16;
  // Result queue depth; one item can push two results
  localparam int unsigned RES_DEPTH = 4;

  // Token kinds
  localparam logic [2:0] KIND_ERROR = 3'd0;
  localparam logic [2:0] KIND_SPACE = 3'd1;
  localparam logic [2:0] KIND_INT   = 3'd2;
  localparam logic [2:0] KIND_FLOAT = 3'd3;
  localparam logic [2:0] KIND_WORD  = 3'd4;

  // Keyword codes
  localparam logic [2:0] KW_NONE = 3'd0;
  localparam int unsigned KW_COUNT = 6;
  localparam logic [KW_COUNT-1:0] KW_ALL = '1;

  // Keyword text, upper case, padded with zero bytes
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{8'h53, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // SET
    '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // GET
    '{8'h44, 8'h45, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // DEL
    '{8'h44, 8'h52, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},  // DROP
    '{8'h50, 8'h4F, 8'h49, 8'h4E, 8'h54, 8'h00, 8'h00, 8'h00},  // POINT
    '{8'h42, 8'h4F, 8'h55, 8'h4E, 8'h44, 8'h53, 8'h00, 8'h00}   // BOUNDS
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd3, 3'd3, 3'd4, 3'd5, 3'd6};

  // Special characters
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BTICK  = 8'h60;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } lex_in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_length;
    logic [2:0]  keyword_code;
    logic        last_token;
  } lex_out_t;

  // Drop keywords that no longer match the byte at position pos
  function automatic logic [KW_COUNT-1:0] kw_update(logic [KW_COUNT-1:0] alive,
                                                    logic [7:0] c, logic pos_ok,
                                                    logic [2:0] pos);
    logic [7:0] up;
    logic [KW_COUNT-1:0] res;
    up  = (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
    res = alive;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!pos_ok || pos >= KW_LEN[k] || KW_TEXT[k][pos] != up) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  // First surviving keyword whose length equals the word length
  function automatic logic [2:0] kw_code(logic [KW_COUNT-1:0] alive, logic len_ok,
                                         logic [2:0] len3);
    logic [2:0] code;
    code = KW_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (alive[k] && len_ok && len3 == KW_LEN[k]) begin
        code = 3'(k + 1);
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// File: hdl/qtl_if.sv
// Valid/ready channels for the query token lexer input and result words.
// Depends on qtl_pkg for the payload types.
`default_nettype none

interface qtl_in_if;
  logic             valid;
  logic             ready;
  qtl_pkg::lex_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qtl_out_if;
  logic              valid;
  logic              ready;
  qtl_pkg::lex_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/query_token_lexer.sv
// Query token lexer top level: mode register, token length counter and a
// small result queue. Depends on qtl_pkg and the qtl_in_if/qtl_out_if channels.
//
//   channel  dir  word                                        flow
//   in_i     in   char_code, end_of_text                       valid/ready
//   out_o    out  token_kind, token_length, keyword_code,
//                 last_token                                  valid/ready
//
// One character word is taken per cycle; it updates the mode state in the
// same cycle and pushes zero, one or two result words into a 4-entry queue.
// in_i.ready drops only while the queue has fewer than two free slots, so
// the rate is one word per cycle as long as out_o keeps up.
// A result is queued as its character is taken; out_o shows results in order.
// Reset (rst_ni low) returns the lexer to idle and empties the queue.
`default_nettype none

module query_token_lexer #(
  parameter int unsigned LENGTH_BITS = qtl_pkg::LENGTH_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  qtl_in_if.sink      in_i,
  qtl_out_if.source   out_o
);

  localparam int unsigned LB    = LENGTH_BITS;
  localparam int unsigned OW    = (LB > 16) ? LB : 16;
  localparam int unsigned DEPTH = qtl_pkg::RES_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned KWN   = qtl_pkg::KW_COUNT;

  // Lexer modes
  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_SPACE = 4'd1;
  localparam logic [3:0] M_WORD  = 4'd2;
  localparam logic [3:0] M_QUOTE = 4'd3;
  localparam logic [3:0] M_PSIGN = 4'd4;
  localparam logic [3:0] M_PDOT  = 4'd5;
  localparam logic [3:0] M_INT   = 4'd6;
  localparam logic [3:0] M_FRACP = 4'd7;
  localparam logic [3:0] M_FRAC  = 4'd8;
  localparam logic [3:0] M_EXPP  = 4'd9;
  localparam logic [3:0] M_EXPS  = 4'd10;
  localparam logic [3:0] M_EXP   = 4'd11;
  localparam logic [3:0] M_DROP  = 4'd12;

  logic [3:0]     mode_q, mode_d;
  logic [LB-1:0]  len_q, len_d;
  logic           dot_q, dot_d;
  logic [7:0]     quote_q, quote_d;
  logic [KWN-1:0] alive_q, alive_d;

  logic [7:0] ch;
  logic       eot;
  logic       is_sp, is_dg, is_ee, is_quote, is_sign;
  logic       accept, pop;

  logic [LB-1:0] inc1, inc2, inc3;

  logic [3:0]     st_mode;
  logic [LB-1:0]  st_len;
  logic [KWN-1:0] st_alive;

  logic              r0_v, r1_v;
  qtl_pkg::lex_out_t r0, r1;
  qtl_pkg::lex_out_t push_a, push_b;
  logic [1:0]        push_n;

  qtl_pkg::lex_out_t res_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     cnt_q;

  // Saturating length add
  function automatic logic [LB-1:0] sat_add(logic [LB-1:0] a, logic [1:0] k);
    logic [LB:0] s;
    s = {1'b0, a} + (LB + 1)'(k);
    return s[LB] ? '1 : s[LB-1:0];
  endfunction

  // Clip a length to the 16-bit result field
  function automatic logic [15:0] clip16(logic [LB-1:0] v);
    logic [OW-1:0] w;
    w = OW'(v);
    return (w > OW'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic qtl_pkg::lex_out_t mk_res(logic [2:0] kind, logic [LB-1:0] len,
                                               logic [2:0] kw, logic last);
    qtl_pkg::lex_out_t r;
    r.token_kind   = kind;
    r.token_length = clip16(len);
    r.keyword_code = kw;
    r.last_token   = last;
    return r;
  endfunction

  // Classify the incoming byte
  assign ch       = in_i.data.char_code;
  assign eot      = in_i.data.end_of_text;
  assign is_sp    = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
  assign is_dg    = (ch >= 8'd48) && (ch <= 8'd57);
  assign is_ee    = (ch == qtl_pkg::CH_LOW_E) || (ch == qtl_pkg::CH_UP_E);
  assign is_sign  = (ch == qtl_pkg::CH_PLUS) || (ch == qtl_pkg::CH_MINUS);
  assign is_quote = (ch == qtl_pkg::CH_SQUOTE) || (ch == qtl_pkg::CH_DQUOTE) ||
                    (ch == qtl_pkg::CH_BTICK);

  assign inc1 = sat_add(len_q, 2'd1);
  assign inc2 = sat_add(len_q, 2'd2);
  assign inc3 = sat_add(len_q, 2'd3);

  // Token start decoded from the current byte
  always_comb begin
    st_alive = qtl_pkg::KW_ALL;
    st_len   = LB'(1);
    if (is_sp) begin
      st_mode = M_SPACE;
    end else if (is_dg) begin
      st_mode = M_INT;
    end else if (is_quote) begin
      st_mode = M_QUOTE;
    end else if (ch == qtl_pkg::CH_MINUS) begin
      st_mode = M_PSIGN;
      st_len  = '0;
    end else if (ch == qtl_pkg::CH_DOT) begin
      st_mode = M_PDOT;
      st_len  = '0;
    end else begin
      st_mode  = M_WORD;
      st_alive = qtl_pkg::kw_update(qtl_pkg::KW_ALL, ch, 1'b1, 3'd0);
    end
  end

  // Mode update, token results and end-of-text flush
  always_comb begin
    logic restart;
    restart = 1'b0;
    mode_d  = mode_q;
    len_d   = len_q;
    dot_d   = dot_q;
    quote_d = quote_q;
    alive_d = alive_q;
    r0_v    = 1'b0;
    r1_v    = 1'b0;
    r0      = mk_res(qtl_pkg::KIND_ERROR, len_q, qtl_pkg::KW_NONE, 1'b0);
    r1      = r0;

    unique case (mode_q)
      M_IDLE: begin
        restart = 1'b1;
      end
      M_SPACE: begin
        if (is_sp) begin
          len_d = inc1;
        end else begin
          r0_v    = 1'b1;
          r0      = mk_res(qtl_pkg::KIND_SPACE, len_q, qtl_pkg::KW_NONE, 1'b0);
          restart = 1'b1;
        end
      end
      M_WORD: begin
        if (is_sp) begin
          r0_v    = 1'b1;
          r0      = mk_res(qtl_pkg::KIND_WORD, len_q,
                           qtl_pkg::kw_code(alive_q, len_q < LB'(8), len_q[2:0]), 1'b0);
          restart = 1'b1;
        end else begin
          alive_d = qtl_pkg::kw_update(alive_q, ch, len_q < LB'(8), len_q[2:0]);
          len_d   = inc1;
        end
      end
      M_QUOTE: begin
        len_d = inc1;
        if (ch == quote_q) begin
          r0_v   = 1'b1;
          r0     = mk_res(qtl_pkg::KIND_WORD, inc1, qtl_pkg::KW_NONE, eot);
          mode_d = M_IDLE;
        end
      end
      M_PSIGN, M_PDOT: begin
        if (is_dg) begin
          dot_d  = (mode_q == M_PDOT);
          len_d  = LB'(2);
          mode_d = M_INT;
        end else if (is_sp) begin
          // lone sign or dot closes as a one-byte word
          r0_v    = 1'b1;
          r0      = mk_res(qtl_pkg::KIND_WORD, LB'(1), qtl_pkg::KW_NONE, 1'b0);
          restart = 1'b1;
        end else begin
          // no keyword starts with a sign or dot
          alive_d = '0;
          len_d   = LB'(2);
          mode_d  = M_WORD;
        end
      end
      M_INT, M_FRAC, M_EXP: begin
        if (is_dg) begin
          len_d = inc1;
        end else if (mode_q == M_INT && ch == qtl_pkg::CH_DOT) begin
          if (dot_q) begin
            r0_v   = 1'b1;
            r0     = mk_res(qtl_pkg::KIND_ERROR, len_q, qtl_pkg::KW_NONE, 1'b1);
            mode_d = M_DROP;
          end else begin
            mode_d = M_FRACP;
          end
        end else if (mode_q != M_EXP && is_ee) begin
          mode_d = M_EXPP;
        end else begin
          r0_v    = 1'b1;
          r0      = mk_res((mode_q == M_INT && !dot_q) ? qtl_pkg::KIND_INT
                                                       : qtl_pkg::KIND_FLOAT,
                           len_q, qtl_pkg::KW_NONE, 1'b0);
          restart = 1'b1;
        end
      end
      M_FRACP, M_EXPP, M_EXPS: begin
        if (is_dg) begin
          len_d  = (mode_q == M_EXPS) ? inc3 : inc2;
          mode_d = (mode_q == M_FRACP) ? M_FRAC : M_EXP;
        end else if (mode_q == M_EXPP && is_sign) begin
          mode_d = M_EXPS;
        end else begin
          r0_v   = 1'b1;
          r0     = mk_res(qtl_pkg::KIND_ERROR, len_q, qtl_pkg::KW_NONE, 1'b1);
          mode_d = M_DROP;
        end
      end
      M_DROP: begin
        mode_d = M_DROP;
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    // Open a new token with the current byte
    if (restart) begin
      mode_d  = st_mode;
      len_d   = st_len;
      alive_d = st_alive;
      dot_d   = 1'b0;
      if (is_quote) begin
        quote_d = ch;
      end
    end

    // Flush the open token at the end of the command
    if (eot) begin
      unique case (mode_d)
        M_SPACE: begin
          r1_v = 1'b1;
          r1   = mk_res(qtl_pkg::KIND_SPACE, len_d, qtl_pkg::KW_NONE, 1'b1);
        end
        M_WORD: begin
          r1_v = 1'b1;
          r1   = mk_res(qtl_pkg::KIND_WORD, len_d,
                        qtl_pkg::kw_code(alive_d, len_d < LB'(8), len_d[2:0]), 1'b1);
        end
        M_PSIGN, M_PDOT: begin
          r1_v = 1'b1;
          r1   = mk_res(qtl_pkg::KIND_WORD, LB'(1), qtl_pkg::KW_NONE, 1'b1);
        end
        M_INT: begin
          r1_v = 1'b1;
          r1   = mk_res(dot_d ? qtl_pkg::KIND_FLOAT : qtl_pkg::KIND_INT, len_d,
                        qtl_pkg::KW_NONE, 1'b1);
        end
        M_FRAC, M_EXP: begin
          r1_v = 1'b1;
          r1   = mk_res(qtl_pkg::KIND_FLOAT, len_d, qtl_pkg::KW_NONE, 1'b1);
        end
        M_QUOTE, M_FRACP, M_EXPP, M_EXPS: begin
          r1_v = 1'b1;
          r1   = mk_res(qtl_pkg::KIND_ERROR, len_d, qtl_pkg::KW_NONE, 1'b1);
        end
        default: begin
          r1_v = 1'b0;
        end
      endcase
      mode_d  = M_IDLE;
      len_d   = '0;
      dot_d   = 1'b0;
      quote_d = '0;
      alive_d = qtl_pkg::KW_ALL;
    end
  end

  // Order the results for the queue
  assign push_a = r0_v ? r0 : r1;
  assign push_b = r1;
  assign push_n = {1'b0, r0_v} + {1'b0, r1_v};

  // Handshakes
  assign in_i.ready  = (cnt_q <= CW'(DEPTH - 2));
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = res_q[rd_ptr_q];
  assign pop         = out_o.valid && out_o.ready;

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      len_q   <= '0;
      dot_q   <= 1'b0;
      quote_q <= '0;
      alive_q <= qtl_pkg::KW_ALL;
    end else if (accept) begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      dot_q   <= dot_d;
      quote_q <= quote_d;
      alive_q <= alive_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (accept && push_n != 2'd0) begin
      res_q[wr_ptr_q] <= push_a;
    end
    if (accept && push_n == 2'd2) begin
      res_q[wr_ptr_q + PW'(1)] <= push_b;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + PW'(push_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q <= cnt_q + (accept ? CW'(push_n) : CW'(0)) - (pop ? CW'(1) : CW'(0));
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> cnt_q + CW'(push_n) <= CW'(DEPTH))
    else $error("result queue overflow on push");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.token_kind == qtl_pkg::KIND_ERROR |-> out_o.data.last_token)
    else $error("error token without last flag");

  a_kw_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.keyword_code != qtl_pkg::KW_NONE
      |-> out_o.data.token_kind == qtl_pkg::KIND_WORD)
    else $error("keyword code on a non-word token");

  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eot |=> mode_q == M_IDLE && len_q == '0)
    else $error("lexer not idle after end of command");

endmodule

`default_nettype wire
